>>> sv/spnc_pkg.sv
package spnc_pkg;

    localparam int SetCapacity = 4096;
    localparam int SetAw = $clog2(SetCapacity);
    localparam int MaxRows = 1024;
    localparam int RowAw = $clog2(MaxRows);
    localparam int CntW = 13;
    localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
    localparam int KeyW = 62;

    typedef enum logic [2:0] {
        ST_NEG_ROW  = 3'd0,
        ST_OFF_ROW  = 3'd1,
        ST_NEG_COL  = 3'd2,
        ST_DUP      = 3'd3,
        ST_NEW_DIAG = 3'd4,
        ST_NEW_OFF  = 3'd5,
        ST_ERROR    = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CFG_ROW_START = 3'd0,
        CFG_ROW_END   = 3'd1,
        CFG_COL_START = 3'd2,
        CFG_COL_END   = 3'd3,
        CFG_BLOCK     = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_CHECK, S_SCAN, S_SCAN_WAIT, S_DECIDE,
        S_CNT_RD, S_CNT_WAIT, S_CNT_WR, S_OUT
    } fsm_t;

endpackage

>>> sv/spnc_ram.sv
module spnc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/spnc_div.sv
module spnc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [30:0] dividend,
    input  logic [6:0]  divisor,
    output logic        busy,
    output logic [30:0] quotient
);
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [30:0] q_reg, q_next;
    logic [6:0]  r_reg, r_next;
    logic [7:0]  trial;

    always_comb begin
        trial = {r_reg, q_reg[30]} - {1'b0, divisor};
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        q_next = q_reg;
        r_next = r_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = 5'd0;
            q_next = dividend;
            r_next = '0;
        end else if (busy_reg) begin
            if (!trial[7]) begin
                r_next = trial[6:0];
                q_next = {q_reg[29:0], 1'b1};
            end else begin
                r_next = {r_reg[5:0], q_reg[30]};
                q_next = {q_reg[29:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd30) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy = busy_reg;
    assign quotient = q_reg;
endmodule

>>> sv/sparse_pattern_nonzero_counter.sv
// A request divides its row, three window bounds and its column by the block size,
// five divisions that share one 31-step divider, then searches the stored set entries
// for a duplicate, passing through a scan state and a scan-wait state for each entry.
// A new request is accepted only after the last result has been taken at the output.
// Synchronous active-low reset; after reset a clearing pass zeroes the row counters
// before the first request is accepted.
module sparse_pattern_nonzero_counter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [30:0]                cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [31:0]         s_row_index,
    input  logic signed [31:0]         s_col_index,
    input  logic                       s_last_in_call,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_status,
    output logic [9:0]                 m_local_block_row,
    output logic [12:0]                m_diag_count,
    output logic [12:0]                m_offdiag_count,
    output logic [12:0]                m_diag_upper_count,
    output logic [12:0]                m_offdiag_upper_count,
    output logic                       m_call_done
);
    import spnc_pkg::*;

    fsm_t state_reg, state_next;
    logic [30:0] row_start_reg, row_end_reg, col_start_reg, col_end_reg;
    logic [6:0]  bs_reg;
    logic [31:0] row_reg, col_reg;
    logic        last_reg;
    logic [2:0]  dstep_reg;
    logic        div_pend_reg;
    logic [30:0] brow_reg, bcol_reg, rsb_reg, csb_reg, ceb_reg;
    logic [RowAw:0] clr_reg;
    logic [SetAw:0] fill_reg, ptr_reg;
    logic        hit_reg;
    status_t     st_reg;
    status_t     dec_status;
    logic [RowAw-1:0] lrow_reg;
    logic [4*CntW-1:0] cnt_reg;
    logic [30:0] lrow_full;

    logic        div_start, div_busy;
    logic [30:0] div_a, div_q;
    logic [6:0]  bs_eff;

    logic        set_we, cnt_we;
    logic [SetAw-1:0] set_raddr;
    logic [KeyW-1:0]  set_rdata, key;
    logic [RowAw-1:0] cnt_addr;
    logic [4*CntW-1:0] cnt_rdata, cnt_wdata, cnt_bump;
    logic [CntW-1:0] c_d, c_o, c_du, c_ou;
    logic [CntW-1:0] r_d, r_o, r_du, r_ou;
    logic [CntW-1:0] n_d, n_o, n_du, n_ou;
    logic        is_diag, is_upper;

    assign bs_eff = (bs_reg == 7'd0) ? 7'd1 : bs_reg;
    assign key = {brow_reg, bcol_reg};
    assign lrow_full = brow_reg - rsb_reg;
    assign is_diag = (bcol_reg >= csb_reg) && (bcol_reg < ceb_reg);
    assign is_upper = bcol_reg >= brow_reg;

    always_comb begin
        case (dstep_reg)
            3'd0: div_a = row_reg[30:0];
            3'd1: div_a = row_start_reg;
            3'd2: div_a = col_start_reg;
            3'd3: div_a = col_end_reg;
            default: div_a = col_reg[30:0];
        endcase
    end

    spnc_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_a),
        .divisor(bs_eff), .busy(div_busy), .quotient(div_q)
    );

    spnc_ram #(.Width(KeyW), .Depth(SetCapacity)) u_set (
        .aclk(aclk), .we(set_we), .waddr(fill_reg[SetAw-1:0]), .wdata(key),
        .raddr(set_raddr), .rdata(set_rdata)
    );

    spnc_ram #(.Width(4*CntW), .Depth(MaxRows)) u_cnt (
        .aclk(aclk), .we(cnt_we), .waddr(cnt_addr), .wdata(cnt_wdata),
        .raddr(cnt_addr), .rdata(cnt_rdata)
    );

    assign set_raddr = ptr_reg[SetAw-1:0];
    assign {c_d, c_o, c_du, c_ou} = cnt_reg;
    assign {r_d, r_o, r_du, r_ou} = cnt_rdata;

    always_comb begin
        if (row_reg[31]) begin
            dec_status = ST_NEG_ROW;
        end else if (row_reg[30:0] < row_start_reg || row_reg[30:0] >= row_end_reg) begin
            dec_status = ST_OFF_ROW;
        end else if (lrow_full >= 31'(MaxRows)) begin
            dec_status = ST_ERROR;
        end else if (col_reg[31]) begin
            dec_status = ST_NEG_COL;
        end else if (hit_reg) begin
            dec_status = ST_DUP;
        end else if (fill_reg == SetCapacity[SetAw:0]) begin
            dec_status = ST_ERROR;
        end else begin
            dec_status = is_diag ? ST_NEW_DIAG : ST_NEW_OFF;
        end
    end

    always_comb begin
        n_d = r_d;
        n_o = r_o;
        n_du = r_du;
        n_ou = r_ou;
        if (st_reg == ST_NEW_DIAG) begin
            n_d = (r_d == CntMax) ? CntMax : r_d + CntW'(1);
            if (is_upper) begin
                n_du = (r_du == CntMax) ? CntMax : r_du + CntW'(1);
            end
        end else if (st_reg == ST_NEW_OFF) begin
            n_o = (r_o == CntMax) ? CntMax : r_o + CntW'(1);
            if (is_upper) begin
                n_ou = (r_ou == CntMax) ? CntMax : r_ou + CntW'(1);
            end
        end
    end

    assign cnt_bump = {n_d, n_o, n_du, n_ou};

    always_comb begin
        cnt_addr = (state_reg == S_IDLE && clr_reg != MaxRows[RowAw:0])
            ? clr_reg[RowAw-1:0] : lrow_reg;
        cnt_we = (clr_reg != MaxRows[RowAw:0]) || (state_reg == S_CNT_WR);
        cnt_wdata = (clr_reg != MaxRows[RowAw:0]) ? '0 : cnt_reg;
        set_we = (state_reg == S_DECIDE) &&
            ((dec_status == ST_NEW_DIAG) || (dec_status == ST_NEW_OFF));
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_valid && clr_reg == MaxRows[RowAw:0]) begin
                state_next = S_DIV;
            end
            S_DIV:       if (div_pend_reg && !div_busy && dstep_reg == 3'd4) begin
                state_next = S_CHECK;
            end
            S_CHECK:     state_next = S_SCAN;
            S_SCAN:      state_next = (ptr_reg == fill_reg || hit_reg) ? S_DECIDE
                                                                        : S_SCAN_WAIT;
            S_SCAN_WAIT: state_next = S_SCAN;
            S_DECIDE:    state_next = S_CNT_RD;
            S_CNT_RD:    state_next = S_CNT_WAIT;
            S_CNT_WAIT:  state_next = S_CNT_WR;
            S_CNT_WR:    state_next = S_OUT;
            S_OUT:       if (m_ready) begin
                state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    assign div_start = (state_reg == S_DIV) && !div_pend_reg;
    assign s_ready = (state_reg == S_IDLE) && (clr_reg == MaxRows[RowAw:0]);
    assign m_valid = state_reg == S_OUT;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            row_start_reg <= '0;
            row_end_reg <= '0;
            col_start_reg <= '0;
            col_end_reg <= '0;
            bs_reg <= 7'd1;
            clr_reg <= '0;
            fill_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (clr_reg != MaxRows[RowAw:0]) begin
                clr_reg <= clr_reg + {{RowAw{1'b0}}, 1'b1};
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ROW_START: row_start_reg <= cfg_data;
                    CFG_ROW_END:   row_end_reg <= cfg_data;
                    CFG_COL_START: col_start_reg <= cfg_data;
                    CFG_COL_END:   col_end_reg <= cfg_data;
                    CFG_BLOCK:     bs_reg <= cfg_data[6:0];
                    default:       ;
                endcase
            end
            if (set_we) begin
                fill_reg <= fill_reg + {{SetAw{1'b0}}, 1'b1};
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                row_reg <= s_row_index;
                col_reg <= s_col_index;
                last_reg <= s_last_in_call;
                dstep_reg <= 3'd0;
                div_pend_reg <= 1'b0;
                st_reg <= ST_NEG_ROW;
                hit_reg <= 1'b0;
                ptr_reg <= '0;
                lrow_reg <= '0;
                cnt_reg <= '0;
            end
            S_DIV: begin
                if (div_start) begin
                    div_pend_reg <= 1'b1;
                end else if (div_pend_reg && !div_busy) begin
                    case (dstep_reg)
                        3'd0: brow_reg <= div_q;
                        3'd1: rsb_reg <= div_q;
                        3'd2: csb_reg <= div_q;
                        3'd3: ceb_reg <= div_q;
                        default: bcol_reg <= div_q;
                    endcase
                    div_pend_reg <= 1'b0;
                    dstep_reg <= dstep_reg + 3'd1;
                end
            end
            S_SCAN: begin
                if (ptr_reg != fill_reg && !hit_reg) begin
                    ptr_reg <= ptr_reg + {{SetAw{1'b0}}, 1'b1};
                end
            end
            S_SCAN_WAIT: begin
                if (set_rdata == key) begin
                    hit_reg <= 1'b1;
                end
            end
            S_DECIDE: begin
                lrow_reg <= lrow_full[RowAw-1:0];
                st_reg <= dec_status;
            end
            S_CNT_WAIT: begin
                cnt_reg <= cnt_bump;
            end
            default: ;
        endcase
    end

    logic zero_out;
    assign zero_out = (st_reg == ST_NEG_ROW) || (st_reg == ST_OFF_ROW) ||
        ((st_reg == ST_ERROR) && (lrow_full >= 31'(MaxRows) || row_reg[31] ||
         row_reg[30:0] < row_start_reg || row_reg[30:0] >= row_end_reg));

    assign m_status = st_reg;
    assign m_local_block_row = zero_out ? '0 : lrow_reg;
    assign m_diag_count = zero_out ? '0 : c_d;
    assign m_offdiag_count = zero_out ? '0 : c_o;
    assign m_diag_upper_count = zero_out ? '0 : c_du;
    assign m_offdiag_upper_count = zero_out ? '0 : c_ou;
    assign m_call_done = last_reg;
endmodule

>>> sv/spnc_checker.sv
module spnc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [12:0] m_diag_count,
    input logic [12:0] m_diag_upper_count
);
    import spnc_pkg::*;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_status))
        else $error("result dropped");
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_ERROR) else $error("bad status");
    a_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_diag_upper_count <= m_diag_count)
        else $error("upper count above total");
endmodule

bind sparse_pattern_nonzero_counter spnc_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_diag_count(m_diag_count), .m_diag_upper_count(m_diag_upper_count)
);

>>> tb/sparse_pattern_nonzero_counter_tb.sv
module sparse_pattern_nonzero_counter_tb;
    import spnc_pkg::*;

    localparam longint CycleLimit = 40_000_000;
    localparam int LocalRows = 1024;
    localparam logic [12:0] CountSat = 13'd8191;

    typedef struct {
        status_t    status;
        logic [9:0]  lrow;
        logic [12:0] diag;
        logic [12:0] offdiag;
        logic [12:0] diag_upper;
        logic [12:0] offdiag_upper;
        logic        done;
    } pair_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [30:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_row_index = '0;
    logic signed [31:0] s_col_index = '0;
    logic               s_last_in_call = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_status;
    logic [9:0]         m_local_block_row;
    logic [12:0]        m_diag_count;
    logic [12:0]        m_offdiag_count;
    logic [12:0]        m_diag_upper_count;
    logic [12:0]        m_offdiag_upper_count;
    logic               m_call_done;

    sparse_pattern_nonzero_counter i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_row_index          (s_row_index),
        .s_col_index          (s_col_index),
        .s_last_in_call       (s_last_in_call),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_local_block_row    (m_local_block_row),
        .m_diag_count         (m_diag_count),
        .m_offdiag_count      (m_offdiag_count),
        .m_diag_upper_count   (m_diag_upper_count),
        .m_offdiag_upper_count(m_offdiag_upper_count),
        .m_call_done          (m_call_done)
    );

    // Shadow copy of the block's registers and counters.
    logic [30:0] row_start_q = '0;
    logic [30:0] row_end_q = '0;
    logic [30:0] col_start_q = '0;
    logic [30:0] col_end_q = '0;
    logic [6:0]  block_size_q = 7'd1;
    bit          seen_pairs[bit [63:0]];
    int          seen_fill = 0;
    logic [12:0] diag_cnt[LocalRows];
    logic [12:0] offdiag_cnt[LocalRows];
    logic [12:0] diag_upper_cnt[LocalRows];
    logic [12:0] offdiag_upper_cnt[LocalRows];

    pair_result_t pending_results[$];
    int           errors = 0;
    longint       cycles = 0;
    bit           quiet = 1'b0;
    int           hold_cycles = 0;
    int           ready_wait = 0;

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic pair_result_t count_pair(logic [31:0] row, logic [31:0] col,
                                                logic last);
        pair_result_t r;
        logic [31:0] bs;
        logic [31:0] brow;
        logic [31:0] bcol;
        logic [31:0] lrow;
        bit [63:0]   key;
        r = '{ST_NEG_ROW, '0, '0, '0, '0, '0, last};
        bs = (block_size_q == 0) ? 32'd1 : {25'd0, block_size_q};
        if (row[31]) return r;
        if (row < row_start_q || row >= row_end_q) begin
            r.status = ST_OFF_ROW;
            return r;
        end
        brow = row / bs;
        lrow = brow - {1'b0, row_start_q} / bs;
        if (lrow >= LocalRows) begin
            r.status = ST_ERROR;
            return r;
        end
        if (col[31]) begin
            r.status = ST_NEG_COL;
        end else begin
            bcol = col / bs;
            key = {brow, bcol};
            if (seen_pairs.exists(key)) begin
                r.status = ST_DUP;
            end else if (seen_fill >= SetCapacity) begin
                r.status = ST_ERROR;
            end else begin
                seen_pairs[key] = 1'b1;
                seen_fill++;
                if (bcol >= {1'b0, col_start_q} / bs && bcol < {1'b0, col_end_q} / bs) begin
                    r.status = ST_NEW_DIAG;
                    if (diag_cnt[lrow] != CountSat) diag_cnt[lrow]++;
                    if (bcol >= brow && diag_upper_cnt[lrow] != CountSat)
                        diag_upper_cnt[lrow]++;
                end else begin
                    r.status = ST_NEW_OFF;
                    if (offdiag_cnt[lrow] != CountSat) offdiag_cnt[lrow]++;
                    if (bcol >= brow && offdiag_upper_cnt[lrow] != CountSat)
                        offdiag_upper_cnt[lrow]++;
                end
            end
        end
        r.lrow = lrow[9:0];
        r.diag = diag_cnt[lrow];
        r.offdiag = offdiag_cnt[lrow];
        r.diag_upper = diag_upper_cnt[lrow];
        r.offdiag_upper = offdiag_upper_cnt[lrow];
        return r;
    endfunction

    task automatic check_field(string name, int expd, int act);
        if (expd != act) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expd, act);
        end
    endtask

    always @(posedge aclk) begin
        pair_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual status %0d",
                         $time, m_status);
            end else begin
                e = pending_results.pop_front();
                check_field("status", e.status, m_status);
                check_field("local_block_row", e.lrow, m_local_block_row);
                check_field("diag_count", e.diag, m_diag_count);
                check_field("offdiag_count", e.offdiag, m_offdiag_count);
                check_field("diag_upper_count", e.diag_upper, m_diag_upper_count);
                check_field("offdiag_upper_count", e.offdiag_upper, m_offdiag_upper_count);
                check_field("call_done", e.done, m_call_done);
            end
            ready_wait = quiet ? 0 : $urandom_range(0, 6);
        end
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else if (ready_wait > 0) begin
                m_ready <= 1'b0;
                ready_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_pair(logic [31:0] row, logic [31:0] col, logic last);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_row_index <= row;
        s_col_index <= col;
        s_last_in_call <= last;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(count_pair(row, col, last));
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (200 + seen_fill) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [30:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ROW_START: row_start_q = value;
            CFG_ROW_END:   row_end_q = value;
            CFG_COL_START: col_start_q = value;
            CFG_COL_END:   col_end_q = value;
            CFG_BLOCK:     block_size_q = value[6:0];
            default: ;
        endcase
    endtask

    task automatic set_window(logic [30:0] rs, logic [30:0] re, logic [30:0] cs,
                              logic [30:0] ce, logic [6:0] bs);
        write_reg(CFG_ROW_START, rs);
        write_reg(CFG_ROW_END, re);
        write_reg(CFG_COL_START, cs);
        write_reg(CFG_COL_END, ce);
        write_reg(CFG_BLOCK, {24'd0, bs});
    endtask

    task automatic test_directed();
        set_window(31'd0, 31'd64, 31'd0, 31'd32, 7'd1);
        send_pair(32'h8000_0000, 32'd0, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'd5, 1'b1);
        send_pair(32'd64, 32'd5, 1'b0);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_pair(32'd3, 32'h8000_0000, 1'b1);
        send_pair(32'd3, 32'd5, 1'b0);
        send_pair(32'd3, 32'd5, 1'b0);
        send_pair(32'd3, 32'd1, 1'b0);
        send_pair(32'd3, 32'd40, 1'b0);
        send_pair(32'd3, 32'h7FFF_FFFF, 1'b1);
        send_pair(32'd0, 32'd0, 1'b0);
        send_pair(32'd63, 32'd2, 1'b1);
        drain();
        set_window(31'd0, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 7'd1);
        send_pair(32'd1024, 32'd1, 1'b0);
        send_pair(32'd1024, 32'hFFFF_FFFF, 1'b0);
        send_pair(32'h7FFF_FFFE, 32'd0, 1'b1);
        send_pair(32'd1023, 32'h7FFF_FFFF, 1'b1);
        drain();
        // A block size of zero acts as one; a start above the end owns no row.
        set_window(31'd100, 31'd10, 31'd0, 31'd50, 7'd0);
        send_pair(32'd50, 32'd3, 1'b0);
        send_pair(32'd100, 32'd3, 1'b1);
        drain();
        set_window(31'd128, 31'd1000, 31'd64, 31'd256, 7'd64);
        send_pair(32'd130, 32'd70, 1'b0);
        send_pair(32'd191, 32'd127, 1'b0);
        send_pair(32'd999, 32'd10, 1'b1);
        drain();
        write_reg(CFG_BLOCK, 31'h7F);
        send_pair(32'd500, 32'd300, 1'b1);
        drain();
    endtask

    task automatic test_random_phases(int phases, int per_phase);
        logic [30:0] rs;
        logic [6:0]  bs;
        logic [31:0] row;
        logic [31:0] col;
        int          pick;
        for (int p = 0; p < phases; p++) begin
            quiet = (p % 4 == 3);
            case (p % 5)
                0: bs = 7'd1;
                1: bs = 7'd64;
                default: bs = 7'($urandom_range(1, 64));
            endcase
            rs = (p == 2) ? 31'h7FFF_F000 : 31'($urandom_range(0, 5000));
            if (p % 3 == 1)
                set_window(rs, 31'(rs + bs * $urandom_range(1, 12)), 31'($urandom),
                           31'($urandom), bs);
            else
                set_window(rs, 31'(rs + bs * $urandom_range(1, 12)),
                           31'($urandom_range(0, 400)), 31'($urandom_range(0, 1200)), bs);
            for (int i = 0; i < per_phase; i++) begin
                pick = $urandom_range(0, 99);
                row = row_start_q - bs + $urandom_range(0, row_end_q - row_start_q + 2 * bs);
                col = $urandom_range(0, 24 * bs);
                if (pick < 8) begin
                    row = $urandom;
                    col = $urandom;
                end else if (pick < 12) begin
                    col = $urandom | 32'h8000_0000;
                end else if (pick < 15) begin
                    row = $urandom | 32'h8000_0000;
                end
                send_pair(row, col, 1'($urandom_range(0, 1)));
            end
            drain();
        end
        quiet = 1'b0;
    endtask

    task automatic test_output_stall();
        set_window(31'd0, 31'd40, 31'd0, 31'd20, 7'd2);
        hold_cycles = 3000;
        for (int i = 0; i < 10; i++)
            send_pair($urandom_range(0, 39), $urandom_range(0, 60), 1'b0);
        drain();
    endtask

    initial begin
        for (int i = 0; i < LocalRows; i++) begin
            diag_cnt[i] = '0;
            offdiag_cnt[i] = '0;
            diag_upper_cnt[i] = '0;
            offdiag_upper_cnt[i] = '0;
        end
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_output_stall();
        test_random_phases(10, 125);
        drain();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
